// ===== rtl/kmsop_pkg.sv =====
// shared constants and codes for the k-mer merge set operation core
package kmsop_pkg;

  // lanes carried on the input word
  localparam int LANES = 4;

  // fixed field widths on the ports
  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam int OUT_CNT_W = 34;
  localparam int LANE_W = KEY_W + CNT_W + 1;
  localparam int IN_DATA_W = ((LANES * LANE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + OUT_CNT_W + 1 + LANES + 1 + 7) / 8) * 8;

  // default datapath widths
  localparam int KEY_BITS_DEF = 64;
  localparam int COUNT_BITS_DEF = 32;

  // configuration port
  localparam int MODE_W = 4;
  localparam int IN_USE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_USE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = 4'd0;
  localparam logic [IN_USE_W-1:0] IN_USE_RESET = 3'd4;

  // set operation codes
  localparam logic [MODE_W-1:0] MODE_UNION = 4'd0;
  localparam logic [MODE_W-1:0] MODE_UNION_MIN = 4'd1;
  localparam logic [MODE_W-1:0] MODE_UNION_MAX = 4'd2;
  localparam logic [MODE_W-1:0] MODE_UNION_SUM = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ISECT = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ISECT_MIN = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ISECT_MAX = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ISECT_SUM = 4'd7;
  localparam logic [MODE_W-1:0] MODE_NONE = 4'd8;

  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_ONE = OUT_CNT_W'(1);

endpackage

// ===== rtl/kmsop_min.sv =====
// smallest-key search: pairwise compare stage, then match mask and key select
module kmsop_min import kmsop_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_BITS-1:0]   in_key [LANES],
  input  logic [COUNT_BITS-1:0] in_cnt [LANES],
  input  logic [LANES-1:0]      in_vld,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [COUNT_BITS-1:0] out_cnt [LANES],
  output logic [LANES-1:0]      out_mask
);

  logic                  b_valid;
  logic                  b_ready;
  logic [KEY_BITS-1:0]   b_key [LANES];
  logic [COUNT_BITS-1:0] b_cnt [LANES];
  logic [LANES-1:0]      b_vld;
  logic [LANES*LANES-1:0] b_lt;
  logic [LANES*LANES-1:0] lt_next;

  logic                  c_valid;
  logic                  c_ready;
  logic [LANES-1:0]      mask_next;
  logic [KEY_BITS-1:0]   key_next;

  assign c_ready = !c_valid || out_ready;
  assign b_ready = !b_valid || c_ready;
  assign in_ready = b_ready;
  assign out_valid = c_valid;

  // lt bit i*LANES+j: lane j holds a strictly smaller key than lane i
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        lt_next[i*LANES+j] = (i != j) && (in_key[j] < in_key[i]);
      end
    end
  end

  // a valid lane is a minimum when no other valid lane beats it;
  // all matching lanes share one key, so an or of the selected keys picks it
  always_comb begin
    mask_next = '0;
    key_next = '0;
    for (int i = 0; i < LANES; i++) begin
      mask_next[i] = b_vld[i];
      for (int j = 0; j < LANES; j++) begin
        if (b_vld[j] && b_lt[i*LANES+j]) begin
          mask_next[i] = 1'b0;
        end
      end
      if (mask_next[i]) begin
        key_next = key_next | b_key[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid <= in_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && b_ready) begin
      b_key <= in_key;
      b_cnt <= in_cnt;
      b_vld <= in_vld;
      b_lt <= lt_next;
    end
    if (b_valid && c_ready) begin
      out_key <= key_next;
      out_cnt <= b_cnt;
      out_mask <= mask_next;
    end
  end

endmodule

// ===== rtl/kmsop_count.sv =====
// count combine: pairwise min/max/sum stage, then final reduce and mode select
module kmsop_count import kmsop_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [COUNT_BITS-1:0] in_cnt [LANES],
  input  logic [LANES-1:0]      in_mask,
  input  logic [MODE_W-1:0]     mode,
  input  logic [LANES-1:0]      use_mask,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [OUT_CNT_W-1:0]  out_count,
  output logic                  out_emit,
  output logic [LANES-1:0]      out_mask,
  output logic                  out_done
);

  localparam int SUM_W = COUNT_BITS + 2;
  localparam int SUM_EXT_W = (SUM_W > OUT_CNT_W) ? SUM_W : OUT_CNT_W;
  localparam int CNT_EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  logic                  d_valid;
  logic                  d_ready;
  logic                  e_ready;
  logic [KEY_BITS-1:0]   d_key;
  logic [LANES-1:0]      d_mask;
  logic [COUNT_BITS:0]   d_sum_lo;
  logic [COUNT_BITS:0]   d_sum_hi;
  logic [COUNT_BITS-1:0] d_min_lo;
  logic [COUNT_BITS-1:0] d_min_hi;
  logic [COUNT_BITS-1:0] d_max_lo;
  logic [COUNT_BITS-1:0] d_max_hi;

  logic [COUNT_BITS-1:0] min_cand [LANES];
  logic [COUNT_BITS-1:0] max_cand [LANES];

  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] cmin;
  logic [COUNT_BITS-1:0] cmax;
  logic [SUM_EXT_W-1:0]  sum_ext;
  logic [CNT_EXT_W-1:0]  min_ext;
  logic [CNT_EXT_W-1:0]  max_ext;
  logic [OUT_CNT_W-1:0]  csum_sat;
  logic [OUT_CNT_W-1:0]  cmin_sat;
  logic [OUT_CNT_W-1:0]  cmax_sat;
  logic                  found;
  logic                  all_match;
  logic [OUT_CNT_W-1:0]  count_next;

  assign e_ready = !out_valid || out_ready;
  assign d_ready = !d_valid || e_ready;
  assign in_ready = d_ready;

  // lanes off the minimum drop out: neutral value for min, zero for max and sum
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      min_cand[i] = in_mask[i] ? in_cnt[i] : '1;
      max_cand[i] = in_mask[i] ? in_cnt[i] : '0;
    end
  end

  always_comb begin
    sum = SUM_W'(d_sum_lo) + SUM_W'(d_sum_hi);
    cmin = (d_min_hi < d_min_lo) ? d_min_hi : d_min_lo;
    cmax = (d_max_hi > d_max_lo) ? d_max_hi : d_max_lo;
    sum_ext = SUM_EXT_W'(sum);
    min_ext = CNT_EXT_W'(cmin);
    max_ext = CNT_EXT_W'(cmax);
    csum_sat = (sum_ext > SUM_EXT_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX : OUT_CNT_W'(sum_ext);
    cmin_sat = (min_ext > CNT_EXT_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX : OUT_CNT_W'(min_ext);
    cmax_sat = (max_ext > CNT_EXT_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX : OUT_CNT_W'(max_ext);
    found = |d_mask;
    all_match = (d_mask == use_mask);
    case (mode)
      MODE_UNION:     count_next = OUT_CNT_ONE;
      MODE_UNION_MIN: count_next = cmin_sat;
      MODE_UNION_MAX: count_next = cmax_sat;
      MODE_UNION_SUM: count_next = csum_sat;
      MODE_ISECT:     count_next = all_match ? OUT_CNT_ONE : '0;
      MODE_ISECT_MIN: count_next = all_match ? cmin_sat : '0;
      MODE_ISECT_MAX: count_next = all_match ? cmax_sat : '0;
      MODE_ISECT_SUM: count_next = all_match ? csum_sat : '0;
      MODE_NONE:      count_next = '0;
      default:        count_next = '0;
    endcase
    if (!found) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid <= in_valid;
      end
      if (e_ready) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && d_ready) begin
      d_key <= in_key;
      d_mask <= in_mask;
      d_sum_lo <= (COUNT_BITS+1)'(max_cand[0]) + (COUNT_BITS+1)'(max_cand[1]);
      d_sum_hi <= (COUNT_BITS+1)'(max_cand[2]) + (COUNT_BITS+1)'(max_cand[3]);
      d_min_lo <= (min_cand[1] < min_cand[0]) ? min_cand[1] : min_cand[0];
      d_min_hi <= (min_cand[3] < min_cand[2]) ? min_cand[3] : min_cand[2];
      d_max_lo <= (max_cand[1] > max_cand[0]) ? max_cand[1] : max_cand[0];
      d_max_hi <= (max_cand[3] > max_cand[2]) ? max_cand[3] : max_cand[2];
    end
    if (d_valid && e_ready) begin
      out_key <= d_key;
      out_count <= count_next;
      out_emit <= |count_next;
      out_mask <= d_mask;
      out_done <= ~|d_mask;
    end
  end

endmodule

// ===== rtl/kmer_merge_set_operation_core.sv =====
// top level of the k-mer merge set operation core: ports, config and input register
//
//  channel  signals                             direction  word
//  s        s_tvalid s_tready s_tdata           in         four stream heads
//  m        m_tvalid m_tready m_tdata           out        merge decision
//  cfg      cfg_valid cfg_ready cfg_index/data  in         register write
//
// one word in and one word out per cycle while m_tready stays high; a result passes
// the input register, key compare, min mask, count pairs and output stages in turn
// every stage holds while the one after it is full and stalled, so m_tready low stalls
// the whole pipe without losing words; s_tready drops only when all stages are full
// reset clears the stage valids and loads mode 0 (union) and four lanes in use
// cfg_ready is always high; writes to unknown indexes are dropped
module kmer_merge_set_operation_core import kmsop_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // per lane a..d from bit 0: key (64), cnt (32), ok (1); zero pad at top
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_key (64), out_count (34), emit (1), advance_mask (4), done_res (1)
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0]     mode;
  logic [IN_USE_W-1:0]   inputs_in_use;
  logic [LANES-1:0]      use_mask;

  logic                  a_valid;
  logic                  a_ready;
  logic [KEY_BITS-1:0]   a_key [LANES];
  logic [COUNT_BITS-1:0] a_cnt [LANES];
  logic [LANES-1:0]      a_vld;

  logic                  mn_valid;
  logic                  mn_ready;
  logic [KEY_BITS-1:0]   mn_key;
  logic [COUNT_BITS-1:0] mn_cnt [LANES];
  logic [LANES-1:0]      mn_mask;

  logic                  cnt_ready;

  logic [KEY_BITS-1:0]   res_key;
  logic [OUT_CNT_W-1:0]  res_count;
  logic                  res_emit;
  logic [LANES-1:0]      res_mask;
  logic                  res_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
      inputs_in_use <= IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   mode <= cfg_data[MODE_W-1:0];
        REG_IN_USE: inputs_in_use <= cfg_data[IN_USE_W-1:0];
        default:    ;
      endcase
    end
  end

  // lanes at or above the lane count take no part
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      use_mask[i] = (IN_USE_W'(i) < inputs_in_use);
    end
  end

  assign s_tready = !a_valid || mn_ready;
  assign a_ready = s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && a_ready) begin
      for (int i = 0; i < LANES; i++) begin
        a_key[i] <= KEY_BITS'(s_tdata[i*LANE_W +: KEY_W]);
        a_cnt[i] <= COUNT_BITS'(s_tdata[i*LANE_W + KEY_W +: CNT_W]);
        a_vld[i] <= s_tdata[i*LANE_W + KEY_W + CNT_W] && use_mask[i];
      end
    end
  end

  kmsop_min #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_min (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (mn_ready),
    .in_key    (a_key),
    .in_cnt    (a_cnt),
    .in_vld    (a_vld),
    .out_valid (mn_valid),
    .out_ready (cnt_ready),
    .out_key   (mn_key),
    .out_cnt   (mn_cnt),
    .out_mask  (mn_mask)
  );

  kmsop_count #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mn_valid),
    .in_ready  (cnt_ready),
    .in_key    (mn_key),
    .in_cnt    (mn_cnt),
    .in_mask   (mn_mask),
    .mode      (mode),
    .use_mask  (use_mask),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_key   (res_key),
    .out_count (res_count),
    .out_emit  (res_emit),
    .out_mask  (res_mask),
    .out_done  (res_done)
  );

  assign m_tdata = OUT_DATA_W'({res_done, res_mask, res_emit, res_count, KEY_W'(res_key)});

endmodule
